// ===== src/d8_steepest_descent_direction_top_macros.svh =====
// Assertion macros for the D8 flow direction block checker.
// Used by d8sdd_checker; no other dependencies.
`ifndef D8_STEEPEST_DESCENT_DIRECTION_TOP_MACROS_SVH
`define D8_STEEPEST_DESCENT_DIRECTION_TOP_MACROS_SVH

// clocked assertion, off while reset is high
`define D8SDD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define D8SDD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/d8sdd_pkg.sv =====
// Shared types and constants for the D8 flow direction block.
// No dependencies.
package d8sdd_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int SAMPLE_W      = 32;
   localparam int GRID_WIDTH_W  = 11;
   localparam int GRID_HEIGHT_W = 16;
   localparam int GRID_MIN      = 5;
   localparam int GRID_RESET    = 1024;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int DIR_W         = 4;
   localparam int RSP_DATA_W    = 8;
   localparam int FIFO_DEPTH    = 16;
   localparam int DROP_W        = SAMPLE_W + 1;
   localparam int SLOPE_W       = DROP_W + 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [DIR_W-1:0] DIR_NONE = DIR_W'(8);

   // 1/sqrt2 in Q0.16
   localparam logic signed [16:0] INV_SQRT2 = 17'sh0B505;

   // window slot (row*3+col) for directions W, NW, N, NE, E, SE, S, SW
   localparam int NBR_POS [8] = '{3, 0, 1, 2, 5, 8, 7, 6};
   localparam int CENTER_POS  = 4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic hit;
      logic ring;
      logic frame_end;
   } ctrl_type;

   typedef struct packed {
      logic                      hit;
      logic [2:0]                dir;
      logic signed [SLOPE_W-1:0] slope;
   } cand_type;

   typedef struct packed {
      logic [DIR_W-1:0] dir;
      logic             last;
   } result_type;

endpackage

// ===== src/d8sdd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module d8sdd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/d8sdd_dir.sv =====
// Steepest descent direction pipeline: drops, slopes, then a registered
// compare tree over the eight neighbors. Depends on d8sdd_pkg.
module d8sdd_dir import d8sdd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_type         in_ctrl,
   input  sample_type       window [9],
   output ctrl_type         out_ctrl,
   output logic [DIR_W-1:0] out_dir
);

   function automatic cand_type pick(cand_type lo, cand_type hi);
      cand_type r;
      if (lo.hit && (!hi.hit || lo.slope >= hi.slope)) begin
         r = lo;
      end else begin
         r = hi;
      end
      return r;
   endfunction

   logic signed [DROP_W-1:0]  drop_in  [8];
   logic signed [DROP_W-1:0]  drop_ff  [8];
   logic signed [SLOPE_W-1:0] slope_in [8];
   logic signed [SLOPE_W-1:0] slope_ff [8];
   cand_type                  lvl1_in  [4];
   cand_type                  lvl1_ff  [4];
   cand_type                  lvl2_in  [2];
   cand_type                  lvl2_ff  [2];
   cand_type                  top_cand;
   cand_type                  leaf     [8];
   logic [DIR_W-1:0]          dir_in;
   logic [DIR_W-1:0]          dir_ff;
   ctrl_type                  ctrl_ff  [5];

   always_comb begin
      for (int n = 0; n < 8; n++) begin
         drop_in[n] = DROP_W'(window[CENTER_POS]) - DROP_W'(window[NBR_POS[n]]);
      end
   end

   always_comb begin
      for (int n = 0; n < 8; n++) begin
         if (n % 2 == 1) begin
            slope_in[n] = drop_ff[n] * INV_SQRT2;
         end else begin
            slope_in[n] = {{(SLOPE_W - DROP_W - 16){drop_ff[n][DROP_W-1]}}, drop_ff[n], 16'b0};
         end
      end
   end

   always_comb begin
      for (int n = 0; n < 8; n++) begin
         leaf[n].hit   = slope_ff[n] > 0;
         leaf[n].dir   = 3'(n);
         leaf[n].slope = slope_ff[n];
      end
      for (int k = 0; k < 4; k++) begin
         lvl1_in[k] = pick(leaf[2*k], leaf[2*k+1]);
      end
      for (int k = 0; k < 2; k++) begin
         lvl2_in[k] = pick(lvl1_ff[2*k], lvl1_ff[2*k+1]);
      end
      top_cand = pick(lvl2_ff[0], lvl2_ff[1]);
      if (ctrl_ff[3].ring || !top_cand.hit) begin
         dir_in = DIR_NONE;
      end else begin
         dir_in = {1'b0, top_cand.dir};
      end
   end

   always_ff @(posedge clock) begin
      drop_ff  <= drop_in;
      slope_ff <= slope_in;
      lvl1_ff  <= lvl1_in;
      lvl2_ff  <= lvl2_in;
      dir_ff   <= dir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 5; s++) begin
            ctrl_ff[s] <= '0;
         end
      end else begin
         ctrl_ff[0] <= in_ctrl;
         for (int s = 1; s < 5; s++) begin
            ctrl_ff[s] <= ctrl_ff[s-1];
         end
      end
   end

   assign out_ctrl = ctrl_ff[4];
   assign out_dir  = dir_ff;

endmodule

// ===== src/d8_steepest_descent_direction_top.sv =====
// D8 flow direction over a raster stream of Q16.16 heights.
// Result path: input regs, window, drops, slopes, compare tree, direction reg, output queue.
// One sample per cycle while ready is high; credits for the 16-entry output queue set ready.
// Reset (synchronous): counters, pipeline control and queue pointers cleared, width/height
// back to 1024 (width capped at MAX_WIDTH); line buffers and data registers are not cleared.
// Depends on d8sdd_pkg, d8sdd_ram, d8sdd_dir.
module d8_steepest_descent_direction_top import d8sdd_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,   // [31:0] height_sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [3:0] flow_direction, [7:4] zero
   output logic                   rsp_tlast,   // frame_end
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);
   localparam logic [GRID_WIDTH_W-1:0] RESET_W =
      GRID_WIDTH_W'((GRID_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_RESET);

   logic [GRID_WIDTH_W-1:0]  eff_w_ff, eff_w_in, wval;
   logic [GRID_HEIGHT_W-1:0] eff_h_ff, eff_h_in, hval;
   logic [CW-1:0]            col_ff, col_in;
   logic [GRID_HEIGHT_W-1:0] row_ff, row_in;
   logic                     accept, cfg_hit, emit, last_col, last_row;
   ctrl_type                 acc_ctrl;

   logic                     p1_valid_ff;
   ctrl_type                 p1_ctrl_ff;
   logic [CW-1:0]            p1_addr_ff;
   sample_type               p1_sample_ff;
   ctrl_type                 p2_ctrl_ff;
   logic [SAMPLE_W-1:0]      upper_rd, middle_rd;
   sample_type               win_ff [9];
   sample_type               win_in [9];

   ctrl_type                 dir_ctrl;
   logic [DIR_W-1:0]         dir_val;

   result_type               fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]         count_ff, count_in, credit_ff, credit_in;
   logic                     push, pop, take;

   assign accept  = req_tvalid && req_tready;
   assign cfg_hit = csr_wr_en && (csr_index == CSR_GRID_WIDTH || csr_index == CSR_GRID_HEIGHT);
   assign wval    = csr_wdata[GRID_WIDTH_W-1:0];
   assign hval    = csr_wdata[GRID_HEIGHT_W-1:0];

   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      if (csr_wr_en && csr_index == CSR_GRID_WIDTH) begin
         if (32'(wval) < GRID_MIN) begin
            eff_w_in = GRID_WIDTH_W'(GRID_MIN);
         end else if (32'(wval) > MAX_WIDTH) begin
            eff_w_in = GRID_WIDTH_W'(MAX_WIDTH);
         end else begin
            eff_w_in = wval;
         end
      end
      if (csr_wr_en && csr_index == CSR_GRID_HEIGHT) begin
         eff_h_in = (32'(hval) < GRID_MIN) ? GRID_HEIGHT_W'(GRID_MIN) : hval;
      end
   end

   assign last_col = 32'(col_ff) == 32'(eff_w_ff) - 32'd1;
   assign last_row = 32'(row_ff) == 32'(eff_h_ff) - 32'd1;
   assign emit     = (32'(col_ff) >= 32'd2) && (32'(row_ff) >= 32'd2);

   always_comb begin
      acc_ctrl.hit       = accept && emit;
      acc_ctrl.ring      = (32'(col_ff) == 32'd2) || (32'(row_ff) == 32'd2) || last_col || last_row;
      acc_ctrl.frame_end = last_col && last_row;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + GRID_HEIGHT_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff    <= RESET_W;
         eff_h_ff    <= GRID_HEIGHT_W'(GRID_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         p1_valid_ff <= 1'b0;
         p1_ctrl_ff  <= '0;
         p2_ctrl_ff  <= '0;
      end else begin
         eff_w_ff    <= eff_w_in;
         eff_h_ff    <= eff_h_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         p1_valid_ff <= accept;
         p1_ctrl_ff  <= acc_ctrl;
         p2_ctrl_ff  <= p1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_addr_ff   <= col_ff;
         p1_sample_ff <= sample_type'(req_tdata);
      end
   end

   d8sdd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper_line (
      .clock   (clock),
      .wr_en   (p1_valid_ff),
      .wr_addr (p1_addr_ff),
      .wr_data (middle_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (upper_rd)
   );

   d8sdd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle_line (
      .clock   (clock),
      .wr_en   (p1_valid_ff),
      .wr_addr (p1_addr_ff),
      .wr_data (p1_sample_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (middle_rd)
   );

   always_comb begin
      win_in = win_ff;
      if (p1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r*3]   = win_ff[r*3+1];
            win_in[r*3+1] = win_ff[r*3+2];
         end
         win_in[2] = sample_type'(upper_rd);
         win_in[5] = sample_type'(middle_rd);
         win_in[8] = p1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   d8sdd_dir u_dir (
      .clock    (clock),
      .reset    (reset),
      .in_ctrl  (p2_ctrl_ff),
      .window   (win_ff),
      .out_ctrl (dir_ctrl),
      .out_dir  (dir_val)
   );

   // output queue; credits cover every result still in flight
   assign push = dir_ctrl.hit;
   assign pop  = rsp_tvalid && rsp_tready;
   assign take = accept && emit;

   always_comb begin
      credit_in = credit_ff;
      if (take && !pop) begin
         credit_in = credit_ff + (FIFO_AW+1)'(1);
      end else if (!take && pop) begin
         credit_in = credit_ff - (FIFO_AW+1)'(1);
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (FIFO_AW+1)'(1);
      end else if (!push && pop) begin
         count_in = count_ff - (FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         credit_ff <= credit_in;
         count_ff  <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{dir: dir_val, last: dir_ctrl.frame_end};
      end
   end

   assign req_tready = credit_ff != (FIFO_AW+1)'(FIFO_DEPTH);
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {{(RSP_DATA_W-DIR_W){1'b0}}, fifo_ff[rd_ptr_ff].dir};
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last;

endmodule

// ===== src/d8sdd_checker.sv =====
// Port-level checker for the D8 flow direction block, bound to the top level.
// Depends on d8sdd_pkg and d8_steepest_descent_direction_top_macros.svh.
`include "d8_steepest_descent_direction_top_macros.svh"

module d8sdd_checker import d8sdd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   `D8SDD_ASSERT_RST(a_reset_idle, reset |=> (!rsp_tvalid && req_tready), "not idle after reset")
   `D8SDD_ASSERT(a_dir_range, rsp_tvalid |-> (rsp_tdata[DIR_W-1:0] <= DIR_NONE && rsp_tdata[RSP_DATA_W-1:DIR_W] == '0), "bad direction code")
   `D8SDD_ASSERT(a_last_is_ring, (rsp_tvalid && rsp_tlast) |-> rsp_tdata[DIR_W-1:0] == DIR_NONE, "frame end cell must give no flow")
   `D8SDD_ASSERT(a_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)), "stalled transfer changed")

endmodule

bind d8_steepest_descent_direction_top d8sdd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
